/* sv/pkcs1_pkg.sv */
// Package for the PKCS#1 v1.5 padding checker: block layout constants,
// request and match types, and the DigestInfo prefix tables.
// No dependencies.
`default_nettype none

package pkcs1_pkg;

	localparam int MAX_BLOCK_BYTES = 512;
	localparam int POS_W           = $clog2(MAX_BLOCK_BYTES);

	localparam int LEAD_BYTES        = 2;
	localparam int SEPARATOR_BYTES   = 1;
	localparam int SHA512_PREFIX_LEN = 19;
	localparam int SHA512_DIGEST_LEN = 64;
	localparam int SHA1_BLOCK_BYTES  = 256;
	localparam int SHA1_PREFIX_LEN   = 15;
	localparam int SHA1_DIGEST_LEN   = 20;
	localparam int PREFIX_IDX_W      = $clog2(SHA512_PREFIX_LEN);

	localparam int SHA512_SEP = MAX_BLOCK_BYTES - SHA512_DIGEST_LEN - SHA512_PREFIX_LEN
		- SEPARATOR_BYTES;
	localparam int SHA512_PRE_END = SHA512_SEP + SEPARATOR_BYTES + SHA512_PREFIX_LEN;
	localparam int SHA1_SEP = SHA1_BLOCK_BYTES - SHA1_DIGEST_LEN - SHA1_PREFIX_LEN
		- SEPARATOR_BYTES;
	localparam int SHA1_PRE_END = SHA1_SEP + SEPARATOR_BYTES + SHA1_PREFIX_LEN;

	localparam logic [7:0] MAXVALUE  = 8'hff;
	localparam logic [7:0] LEAD_ZERO = 8'h00;
	localparam logic [7:0] BLOCK_TYPE = 8'h01;

	localparam logic MODE_SHA512 = 1'b0;
	localparam logic MODE_SHA1   = 1'b1;

	typedef struct packed {
		logic       block_start;
		logic [7:0] digest;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic match;
		logic last;
	} match_t;

	function automatic logic [7:0] prefix_sha512(input logic [PREFIX_IDX_W-1:0] idx);
		logic [7:0] v;
		case (idx)
			5'd0:  v = 8'h30;
			5'd1:  v = 8'h51;
			5'd2:  v = 8'h30;
			5'd3:  v = 8'h0d;
			5'd4:  v = 8'h06;
			5'd5:  v = 8'h09;
			5'd6:  v = 8'h60;
			5'd7:  v = 8'h86;
			5'd8:  v = 8'h48;
			5'd9:  v = 8'h01;
			5'd10: v = 8'h65;
			5'd11: v = 8'h03;
			5'd12: v = 8'h04;
			5'd13: v = 8'h02;
			5'd14: v = 8'h03;
			5'd15: v = 8'h05;
			5'd16: v = 8'h00;
			5'd17: v = 8'h04;
			5'd18: v = 8'h40;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] prefix_sha1(input logic [PREFIX_IDX_W-1:0] idx);
		logic [7:0] v;
		case (idx)
			5'd0:  v = 8'h30;
			5'd1:  v = 8'h21;
			5'd2:  v = 8'h30;
			5'd3:  v = 8'h09;
			5'd4:  v = 8'h06;
			5'd5:  v = 8'h05;
			5'd6:  v = 8'h2b;
			5'd7:  v = 8'h0e;
			5'd8:  v = 8'h03;
			5'd9:  v = 8'h02;
			5'd10: v = 8'h1a;
			5'd11: v = 8'h05;
			5'd12: v = 8'h00;
			5'd13: v = 8'h04;
			5'd14: v = 8'h14;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* sv/pkcs1_byte_match.sv */
// Judges one block byte against the expected encoding at a given position.
// Depends on pkcs1_pkg.
`default_nettype none

module pkcs1_byte_match
	import pkcs1_pkg::*;
(
	input  wire logic             mode,
	input  wire logic [POS_W-1:0] pos,
	input  wire logic [7:0]       data,
	input  wire logic [7:0]       digest,
	output match_t                result
);

	logic [POS_W-1:0]        sep;
	logic [POS_W-1:0]        pre_end;
	logic [POS_W-1:0]        last_pos;
	logic [POS_W-1:0]        pre_off;
	logic [PREFIX_IDX_W-1:0] pre_idx;
	logic [7:0]              pre_byte;

	always_comb begin
		if (mode == MODE_SHA1) begin
			sep      = POS_W'(SHA1_SEP);
			pre_end  = POS_W'(SHA1_PRE_END);
			last_pos = POS_W'(SHA1_BLOCK_BYTES - 1);
		end else begin
			sep      = POS_W'(SHA512_SEP);
			pre_end  = POS_W'(SHA512_PRE_END);
			last_pos = POS_W'(MAX_BLOCK_BYTES - 1);
		end
		// offset into the DigestInfo prefix; only meaningful inside it
		pre_off  = pos - sep - POS_W'(SEPARATOR_BYTES);
		pre_idx  = pre_off[PREFIX_IDX_W-1:0];
		pre_byte = (mode == MODE_SHA1) ? prefix_sha1(pre_idx) : prefix_sha512(pre_idx);

		if (pos == '0)
			result.match = (data == LEAD_ZERO);
		else if (pos == POS_W'(1))
			result.match = (data == BLOCK_TYPE);
		else if (pos < sep)
			result.match = (data == MAXVALUE);
		else if (pos == sep)
			result.match = (data == LEAD_ZERO);
		else if (pos < pre_end)
			result.match = (data == pre_byte);
		else if (pos <= last_pos)
			result.match = (data == digest);
		else
			result.match = 1'b0;

		// a position past the end only follows a mode change; it closes the block
		result.last = (pos >= last_pos);
	end

endmodule

`default_nettype wire

/* sv/pkcs1_v15_padding_checker_unit.sv */
// Streaming PKCS#1 v1.5 signature-encoding checker, one byte per request.
// Depends on pkcs1_pkg and pkcs1_byte_match.
//
// Usage:
//   s_axis carries one block byte per request: tdata[7:0] is the block byte,
//   tdata[15:8] the expected digest byte, tuser[0] flags the first byte of a
//   block (clears position and verdict). Bytes arrive most significant first.
//   m_axis returns one result per request: tdata[0] is the running verdict
//   (1 = every byte so far matched), tlast marks the final byte of the block,
//   on which tdata[0] is the verdict for the whole block.
//   cfg_wr_en/cfg_wr_data[0] select the layout: 0 = SHA-512, 512-byte block,
//   1 = SHA-1, 256-byte block. Write only while no request is in flight.
// Timing:
//   A request is taken into an input register, then compared against the
//   position-selected constant, and its result is held in the output register
//   that drives m_axis. One request per cycle is sustained while the receiver
//   takes every result. When the receiver stalls, the result holds and one
//   more request is taken into the input register, after which s_axis_tready
//   drops until the result is taken.
//   Reset clears position, verdict, mode (SHA-512) and both valid flags.
`default_nettype none

module pkcs1_v15_padding_checker_unit
	import pkcs1_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [7:0] block_byte, [15:8] expected_digest_byte
	input  wire logic [0:0]  s_axis_tuser,  // [0] block_start

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [0] still_valid, [7:1] zero
	output logic             m_axis_tlast,  // block_end

	input  wire logic        cfg_wr_en,
	input  wire logic [0:0]  cfg_wr_data    // [0] hash_mode
);

	logic             mode_q;
	logic [POS_W-1:0] pos_q;
	logic             mismatch_q;

	item_t            item_s1;
	logic             valid_s1;
	logic             valid_s2;
	logic             still_valid_s2;
	logic             block_end_s2;

	logic             advance;
	logic             accept;
	logic [POS_W-1:0] cur_pos;
	logic             cur_mismatch;
	logic             new_mismatch;
	match_t           judged;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// block start restarts the count before the byte is judged
	assign cur_pos      = item_s1.block_start ? '0 : pos_q;
	assign cur_mismatch = item_s1.block_start ? 1'b0 : mismatch_q;
	assign new_mismatch = cur_mismatch || !judged.match;

	pkcs1_byte_match u_match (
		.mode   (mode_q),
		.pos    (cur_pos),
		.data   (item_s1.data),
		.digest (item_s1.digest),
		.result (judged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SHA512;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data        <= s_axis_tdata[7:0];
			item_s1.digest      <= s_axis_tdata[15:8];
			item_s1.block_start <= s_axis_tuser[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			mismatch_q <= 1'b0;
		end else if (advance) begin
			if (judged.last) begin
				pos_q      <= '0;
				mismatch_q <= 1'b0;
			end else begin
				pos_q      <= cur_pos + POS_W'(1);
				mismatch_q <= new_mismatch;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			still_valid_s2 <= !new_mismatch;
			block_end_s2   <= judged.last;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, still_valid_s2};
	assign m_axis_tlast  = block_end_s2;

endmodule

`default_nettype wire

/* sv/pkcs1_checker.sv */
// Port-level assertions for the padding checker, bound to the top level.
// Depends on pkcs1_v15_padding_checker_unit.
`default_nettype none

module pkcs1_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [7:0]  m_axis_tdata,
	input wire logic        m_axis_tlast
);

	// no result while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	// a stalled result keeps its contents
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// input only backs up when the output is stalled
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output stall");

	// a fresh result traces back to an accepted request
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without matching request");

endmodule

bind pkcs1_v15_padding_checker_unit pkcs1_checker u_pkcs1_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* sim/pkcs1_v15_padding_checker_unit_test.sv */
// Self-checking bench for pkcs1_v15_padding_checker_unit: streams recovered blocks
// byte by byte, predicts the running verdict and compares every result.
// Depends on pkcs1_pkg and the checker RTL.
`default_nettype none

module pkcs1_v15_padding_checker_unit_test;
	import pkcs1_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int RANDOM_ITEMS   = 1050;
	localparam int HOLD_OFF_AT    = 1500;
	localparam int HOLD_OFF_LEN   = 400;

	// Tracks the position and mismatch flag of the block and queues the verdicts due.
	class verdict_tracker;
		logic       hash_mode;
		logic [9:0] byte_pos;
		logic       mismatch_seen;
		match_t     verdicts_due[$];
		int         errors;

		function new();
			hash_mode     = MODE_SHA512;
			byte_pos      = '0;
			mismatch_seen = 1'b0;
			errors        = 0;
		endfunction

		function int block_bytes();
			return (hash_mode == MODE_SHA1) ? SHA1_BLOCK_BYTES : MAX_BLOCK_BYTES;
		endfunction

		// Byte the encoding calls for at pos; 0 when pos lies past the block.
		function bit layout_byte(logic [9:0] pos, logic [7:0] dig, output logic [7:0] want);
			int len, plen, dlen, sep, pre_end, k;
			logic [7:0] pre512 [19];
			logic [7:0] pre160 [15];
			pre512 = '{8'h30, 8'h51, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
				8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40};
			pre160 = '{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h0e, 8'h03, 8'h02,
				8'h1a, 8'h05, 8'h00, 8'h04, 8'h14};
			len  = block_bytes();
			plen = (hash_mode == MODE_SHA1) ? SHA1_PREFIX_LEN : SHA512_PREFIX_LEN;
			dlen = (hash_mode == MODE_SHA1) ? SHA1_DIGEST_LEN : SHA512_DIGEST_LEN;
			sep     = len - dlen - plen - SEPARATOR_BYTES;
			pre_end = sep + SEPARATOR_BYTES + plen;
			want = 8'h00;
			if (pos == 0) begin
				want = LEAD_ZERO;
			end else if (pos == 1) begin
				want = BLOCK_TYPE;
			end else if (pos < sep) begin
				want = MAXVALUE;
			end else if (pos == sep) begin
				want = 8'h00;
			end else if (pos < pre_end) begin
				k = pos - sep - SEPARATOR_BYTES;
				if (hash_mode == MODE_SHA1)
					want = pre160[k];
				else
					want = pre512[k];
			end else if (pos < len) begin
				want = dig;
			end else begin
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void take_byte(logic [7:0] b, logic [7:0] dig, logic start);
			logic [7:0] want;
			bit         in_block;
			bit         last;
			match_t     v;
			if (start) begin
				byte_pos      = '0;
				mismatch_seen = 1'b0;
			end
			in_block = layout_byte(byte_pos, dig, want);
			if (!in_block || b != want)
				mismatch_seen = 1'b1;
			last = (byte_pos >= block_bytes() - 1);
			v.match = !mismatch_seen;
			v.last  = last;
			verdicts_due.push_back(v);
			if (last) begin
				byte_pos      = '0;
				mismatch_seen = 1'b0;
			end else begin
				byte_pos = byte_pos + 10'd1;
			end
		endfunction

		function void check_verdict(logic still_valid, logic block_end);
			match_t v;
			if (verdicts_due.size() == 0) begin
				$error("unexpected result: still_valid %0b block_end %0b", still_valid,
					block_end);
				errors++;
				return;
			end
			v = verdicts_due.pop_front();
			if (still_valid !== v.match) begin
				$error("still_valid: expected %0b, got %0b", v.match, still_valid);
				errors++;
			end
			if (block_end !== v.last) begin
				$error("block_end: expected %0b, got %0b", v.last, block_end);
				errors++;
			end
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_wr_en = 1'b0;
	logic [0:0]  cfg_wr_data = '0;

	verdict_tracker tracker = new();
	int sent = 0;
	int burst_left = 0;

	pkcs1_v15_padding_checker_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Sender pacing: bursts of random length, random gaps between them.
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 48);
		end
	endtask

	task automatic send_item(logic [7:0] b, logic [7:0] dig, logic start);
		s_axis_tdata  <= {dig, b};
		s_axis_tuser  <= start;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		tracker.take_byte(b, dig, start);
		sent++;
		pace();
	endtask

	// Mode register is only touched once every request has drained.
	task automatic write_mode(logic mode);
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() > 0) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.hash_mode = mode;
	endtask

	// One byte that follows the layout at the current position, optionally spoilt.
	task automatic send_encoded(logic start, int spoil_one_in);
		logic [7:0] dig, want, b;
		logic [9:0] pos;
		dig = 8'($urandom_range(0, 255));
		pos = start ? 10'd0 : tracker.byte_pos;
		if (tracker.layout_byte(pos, dig, want))
			b = want;
		else
			b = 8'($urandom_range(0, 255));
		if (spoil_one_in > 0 && $urandom_range(1, spoil_one_in) == 1)
			b = b ^ (8'h01 << $urandom_range(0, 7));
		send_item(b, dig, start);
	endtask

	task automatic send_block(int spoil_one_in, logic use_start, bit may_abort);
		bit stop;
		stop = 1'b0;
		send_encoded(use_start || tracker.byte_pos != 0, spoil_one_in);
		while (tracker.byte_pos != 0 && !stop) begin
			send_encoded(1'b0, spoil_one_in);
			if (may_abort && $urandom_range(0, 599) == 0)
				stop = 1'b1;
		end
	endtask

	// Switch layout part way through a block, then run the block out.
	task automatic switch_mid_block(logic first_mode, int lead);
		if (tracker.hash_mode != first_mode)
			write_mode(first_mode);
		send_encoded(1'b1, 0);
		repeat (lead) send_encoded(1'b0, 0);
		write_mode(~first_mode);
		while (tracker.byte_pos != 0)
			send_encoded(1'b0, 0);
	endtask

	task automatic send_noise(int n);
		repeat (n)
			send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				$urandom_range(0, 3) == 0);
	endtask

	// Receiver: stall pattern picked at random from four styles, one long hold-off.
	initial begin
		int cyc;
		int style;
		cyc   = 0;
		style = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == HOLD_OFF_AT) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_LEN) @(posedge clk);
				cyc += HOLD_OFF_LEN;
			end
			if (cyc % 64 == 0)
				style = $urandom_range(0, 3);
			case (style)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ~m_axis_tready;
				default: m_axis_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_verdict(m_axis_tdata[0], m_axis_tlast);
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int scenario;
		int iter;
		int target;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: SHA-512 layout straight out of reset
		send_item(8'h00, 8'h00, 1'b1);
		send_item(8'h01, 8'hff, 1'b0);
		send_item(8'hff, 8'h00, 1'b0);
		send_item(8'hfe, 8'hff, 1'b0);   // bad padding byte
		send_item(8'hff, 8'h00, 1'b0);   // verdict stays failed
		send_item(8'h00, 8'h55, 1'b1);   // restart clears the verdict
		send_item(8'h00, 8'haa, 1'b0);
		send_item(8'hff, 8'hff, 1'b1);
		send_item(8'h00, 8'h00, 1'b1);
		send_item(8'h01, 8'h00, 1'b0);
		send_item(8'h7f, 8'h80, 1'b0);
		write_mode(MODE_SHA1);
		send_item(8'h00, 8'hff, 1'b1);
		send_item(8'h01, 8'h00, 1'b0);
		send_item(8'hff, 8'hff, 1'b0);
		send_item(8'h80, 8'h7f, 1'b0);

		target = sent + RANDOM_ITEMS;
		iter   = 0;
		while (sent < target) begin
			if (iter == 0)
				scenario = 0;
			else if (iter == 1)
				scenario = 9;
			else if (iter == 2)
				scenario = 13;
			else
				scenario = $urandom_range(0, 15);
			case (scenario)
				9, 10: begin
					if (tracker.hash_mode != MODE_SHA512)
						write_mode(MODE_SHA512);
					send_block((iter == 1 || $urandom_range(0, 1)) ? 0 : 150, 1'b1, iter != 1);
				end
				11, 12: begin
					if ($urandom_range(0, 1))
						write_mode(1'($urandom_range(0, 1)));
					send_noise($urandom_range(4, 30));
				end
				13: switch_mid_block(MODE_SHA512, $urandom_range(SHA1_BLOCK_BYTES - 10, 400));
				14: switch_mid_block(1'($urandom_range(0, 1)),
					$urandom_range(0, SHA1_BLOCK_BYTES - 2));
				15: begin
					// back to back, the second block relying on the wrap alone
					if (tracker.hash_mode != MODE_SHA1)
						write_mode(MODE_SHA1);
					send_block(0, 1'b1, 1'b0);
					send_block(200, 1'b0, 1'b0);
				end
				default: begin
					if (tracker.hash_mode != MODE_SHA1)
						write_mode(MODE_SHA1);
					send_block((iter == 0 || $urandom_range(0, 2) != 0) ? 0 : 100, 1'b1,
						iter != 0);
				end
			endcase
			iter++;
		end

		s_axis_tvalid <= 1'b0;
		while (tracker.pending() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
sv/pkcs1_pkg.sv
sv/pkcs1_byte_match.sv
sv/pkcs1_v15_padding_checker_unit.sv
sv/pkcs1_checker.sv
sim/pkcs1_v15_padding_checker_unit_test.sv
